// ----- design/summed_area_table_query_core_macros.svh -----
// Assertion macros shared by the summed-area table query core.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SUMMED_AREA_TABLE_QUERY_CORE_MACROS_SVH
`define SUMMED_AREA_TABLE_QUERY_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SATQ_ASSERT_SAME(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SATQ_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/satq_pkg.sv -----
// Package for the summed-area table query core: payload structs, queue entry type
// and fixed constants. No dependencies.
package satq_pkg;

    localparam int IDX_W      = 7;
    localparam int VAL_W      = 16;
    localparam int SUM_W      = 30;
    localparam int CFG_W      = 8;
    localparam int ADDR_MAX_W = 20;
    localparam int TERMS      = 4;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic REG_NUM_ROWS = 1'b0;
    localparam logic REG_NUM_COLS = 1'b1;

    localparam logic [CFG_W-1:0] SIZE_RESET = 8'd128;

    typedef struct packed {
        logic                    kind;
        logic signed [VAL_W-1:0] value;
        logic [IDX_W-1:0]        top_row;
        logic [IDX_W-1:0]        left_col;
        logic [IDX_W-1:0]        bottom_row;
        logic [IDX_W-1:0]        right_col;
    } in_item_t;

    typedef struct packed {
        logic signed [SUM_W-1:0] rect_sum;
        logic                    bad_query;
    } result_t;

    typedef enum logic [1:0] {
        OP_LOAD,
        OP_QUERY,
        OP_BAD
    } op_t;

    // One classified transaction. For a load, addr[0] is the entry written,
    // addr[1] the entry above and data the new row running sum. For a query,
    // addr[0..3] are the four corners in inclusion-exclusion order.
    typedef struct packed {
        op_t                                op;
        logic [TERMS-1:0]                   term_en;
        logic [TERMS-1:0][ADDR_MAX_W-1:0]   addr;
        logic [SUM_W-1:0]                   data;
    } entry_t;

endpackage

// ----- design/satq_ram.sv -----
// Generic single-port RAM with registered read data.
// No dependencies.
module satq_ram #(
    parameter int WIDTH = 30,
    parameter int DEPTH = 16384
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (we)
            begin
                mem[addr] <= wdata;
            end
            else
            begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/satq_front.sv -----
// Front end: size registers, load position tracking and classification of each
// transaction into a queue entry. Depends on satq_pkg.
module satq_front #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       accept,
    input  satq_pkg::in_item_t         item,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [satq_pkg::CFG_W-1:0] cfg_data,
    output logic                       push,
    output satq_pkg::entry_t           entry
);

    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int RCNT_W  = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W  = $clog2(MAX_COLS + 1);
    localparam int AW      = satq_pkg::ADDR_MAX_W;
    localparam int SW      = satq_pkg::SUM_W;

    logic [satq_pkg::CFG_W-1:0] num_rows_reg, num_rows_next;
    logic [satq_pkg::CFG_W-1:0] num_cols_reg, num_cols_next;
    logic [ROW_W-1:0]           load_row_reg, load_row_next;
    logic [COL_W-1:0]           load_col_reg, load_col_next;
    logic [SW-1:0]              run_sum_reg, run_sum_next;

    logic [RCNT_W-1:0] rows_use;
    logic [CCNT_W-1:0] cols_use;
    logic [31:0]       raw_value;
    logic [31:0]       elem_ext;
    logic [SW-1:0]     sum_new;
    logic              col_last;
    logic              row_last;
    logic              bad;
    logic [ROW_W-1:0]  q_b, q_t1;
    logic [COL_W-1:0]  q_r, q_l1;
    logic              has_top, has_left;

    function automatic logic [AW-1:0] addr_of(input logic [ROW_W-1:0] row,
                                              input logic [COL_W-1:0] col);
        addr_of = AW'(row) * AW'(MAX_COLS) + AW'(col);
    endfunction

    // Sizes in use are the registers saturated to 1..MAX.
    always_comb
    begin
        if (num_rows_reg == '0)
            rows_use = RCNT_W'(1);
        else if (32'(num_rows_reg) > 32'(MAX_ROWS))
            rows_use = RCNT_W'(MAX_ROWS);
        else
            rows_use = RCNT_W'(num_rows_reg);

        if (num_cols_reg == '0)
            cols_use = CCNT_W'(1);
        else if (32'(num_cols_reg) > 32'(MAX_COLS))
            cols_use = CCNT_W'(MAX_COLS);
        else
            cols_use = CCNT_W'(num_cols_reg);
    end

    // Element value: low VALUE_WIDTH bits taken as two's complement.
    assign raw_value = {{(32 - satq_pkg::VAL_W){1'b0}}, item.value};
    assign elem_ext  = 32'(signed'(raw_value[VALUE_WIDTH-1:0]));
    assign sum_new   = run_sum_reg + elem_ext[SW-1:0];

    assign col_last = (32'(load_col_reg) + 32'd1) >= 32'(cols_use);
    assign row_last = (32'(load_row_reg) + 32'd1) >= 32'(rows_use);

    assign bad = (item.top_row > item.bottom_row) || (item.left_col > item.right_col)
              || (32'(item.bottom_row) >= 32'(rows_use))
              || (32'(item.right_col) >= 32'(cols_use));

    assign has_top  = item.top_row != '0;
    assign has_left = item.left_col != '0;
    assign q_b  = ROW_W'(item.bottom_row);
    assign q_r  = COL_W'(item.right_col);
    assign q_t1 = ROW_W'(item.top_row - satq_pkg::IDX_W'(1));
    assign q_l1 = COL_W'(item.left_col - satq_pkg::IDX_W'(1));

    always_comb
    begin
        entry   = '0;
        push    = accept;
        if (item.kind == 1'b0)
        begin
            entry.op         = satq_pkg::OP_LOAD;
            entry.data       = sum_new;
            entry.term_en[0] = 1'b1;
            entry.term_en[1] = load_row_reg != '0;
            entry.addr[0]    = addr_of(load_row_reg, load_col_reg);
            entry.addr[1]    = addr_of(load_row_reg - ROW_W'(1), load_col_reg);
        end
        else if (bad)
        begin
            entry.op = satq_pkg::OP_BAD;
        end
        else
        begin
            entry.op      = satq_pkg::OP_QUERY;
            entry.term_en = {has_top && has_left, has_left, has_top, 1'b1};
            entry.addr[0] = addr_of(q_b, q_r);
            entry.addr[1] = addr_of(q_t1, q_r);
            entry.addr[2] = addr_of(q_b, q_l1);
            entry.addr[3] = addr_of(q_t1, q_l1);
        end
    end

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        load_row_next = load_row_reg;
        load_col_next = load_col_reg;
        run_sum_next  = run_sum_reg;
        if (cfg_we)
        begin
            // A size write restarts loading; table contents stay.
            case (cfg_index)
                satq_pkg::REG_NUM_ROWS: num_rows_next = cfg_data;
                satq_pkg::REG_NUM_COLS: num_cols_next = cfg_data;
                default:                num_rows_next = num_rows_reg;
            endcase
            load_row_next = '0;
            load_col_next = '0;
            run_sum_next  = '0;
        end
        else if (accept && item.kind == 1'b0)
        begin
            if (col_last)
            begin
                load_col_next = '0;
                run_sum_next  = '0;
                load_row_next = row_last ? '0 : load_row_reg + ROW_W'(1);
            end
            else
            begin
                load_col_next = load_col_reg + COL_W'(1);
                run_sum_next  = sum_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg <= satq_pkg::SIZE_RESET;
            num_cols_reg <= satq_pkg::SIZE_RESET;
            load_row_reg <= '0;
            load_col_reg <= '0;
            run_sum_reg  <= '0;
        end
        else
        begin
            num_rows_reg <= num_rows_next;
            num_cols_reg <= num_cols_next;
            load_row_reg <= load_row_next;
            load_col_reg <= load_col_next;
            run_sum_reg  <= run_sum_next;
        end
    end

endmodule

// ----- design/satq_queue.sv -----
// Two-entry queue of classified transactions between front and back end.
// Depends on satq_pkg and the assertion macro header.
`include "summed_area_table_query_core_macros.svh"

module satq_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  satq_pkg::entry_t push_data,
    input  logic             pop,
    output satq_pkg::entry_t pop_data,
    output logic             empty,
    output logic             full
);

    satq_pkg::entry_t                 slots [satq_pkg::QUEUE_DEPTH];
    logic [satq_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [satq_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [satq_pkg::QCNT_W-1:0]      count_reg, count_next;

    assign empty    = count_reg == '0;
    assign full     = count_reg == satq_pkg::QCNT_W'(satq_pkg::QUEUE_DEPTH);
    assign pop_data = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + satq_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + satq_pkg::QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
            count_next = count_reg + satq_pkg::QCNT_W'(1);
        else if (pop && !push)
            count_next = count_reg - satq_pkg::QCNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `SATQ_ASSERT_SAME(a_no_push_when_full, push, !full, "queue pushed while full")
    `SATQ_ASSERT_SAME(a_no_pop_when_empty, pop, !empty, "queue popped while empty")

endmodule

// ----- design/satq_back.sv -----
// Back end: executes queued loads and queries against the prefix table RAM
// and drives the result strobe. Depends on satq_pkg, satq_ram and the macro header.
`include "summed_area_table_query_core_macros.svh"

module satq_back #(
    parameter int MAX_ROWS = 128,
    parameter int MAX_COLS = 128
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               empty,
    input  satq_pkg::entry_t   head,
    output logic               pop,
    output logic               done,
    output satq_pkg::result_t  result
);

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);
    localparam int SW    = satq_pkg::SUM_W;
    localparam int TW    = satq_pkg::TERMS;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_RD,
        S_LD_WR,
        S_Q_RUN,
        S_Q_DRAIN,
        S_EMIT
    } state_t;

    state_t                                        state_reg, state_next;
    logic [TW-1:0][satq_pkg::ADDR_MAX_W-1:0]       addr_reg, addr_next;
    logic [TW-1:0]                                 term_en_reg, term_en_next;
    logic [SW-1:0]                                 data_reg, data_next;
    logic [SW-1:0]                                 acc_reg, acc_next;
    logic [1:0]                                    k_reg, k_next;
    logic                                          prev_use_reg, prev_use_next;
    logic                                          prev_neg_reg, prev_neg_next;
    logic                                          done_reg, done_next;
    satq_pkg::result_t                             result_reg, result_next;

    logic          ram_en, ram_we;
    logic [AW-1:0] ram_addr;
    logic [SW-1:0] ram_wdata, ram_rdata;
    logic [SW-1:0] term;
    logic          finishing;

    satq_ram #(
        .WIDTH (SW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // Signed contribution of the entry read in the previous cycle.
    assign term = prev_use_reg ? (prev_neg_reg ? SW'(0) - ram_rdata : ram_rdata) : '0;

    // States in which the RAM port frees up, so the next entry may be taken.
    assign finishing = state_reg inside {S_IDLE, S_LD_WR, S_Q_DRAIN, S_EMIT};
    assign pop       = !empty && finishing;

    always_comb
    begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        term_en_next  = term_en_reg;
        data_next     = data_reg;
        acc_next      = acc_reg;
        k_next        = k_reg;
        prev_use_next = prev_use_reg;
        prev_neg_next = prev_neg_reg;
        done_next     = 1'b0;
        result_next   = result_reg;
        ram_en        = 1'b0;
        ram_we        = 1'b0;
        ram_addr      = addr_reg[0][AW-1:0];
        ram_wdata     = data_reg + (term_en_reg[1] ? ram_rdata : '0);

        unique case (state_reg)
            S_IDLE:
            begin
                state_next = S_IDLE;
            end
            S_LD_RD:
            begin
                ram_en     = 1'b1;
                ram_addr   = addr_reg[1][AW-1:0];
                state_next = S_LD_WR;
            end
            S_LD_WR:
            begin
                ram_en     = 1'b1;
                ram_we     = 1'b1;
                state_next = S_IDLE;
            end
            S_Q_RUN:
            begin
                ram_en        = 1'b1;
                ram_addr      = addr_reg[k_reg][AW-1:0];
                acc_next      = acc_reg + term;
                prev_use_next = term_en_reg[k_reg];
                // Corner terms alternate plus, minus, minus, plus.
                prev_neg_next = k_reg[0] ^ k_reg[1];
                k_next        = k_reg + 2'd1;
                if (k_reg == 2'd3)
                    state_next = S_Q_DRAIN;
            end
            S_Q_DRAIN:
            begin
                done_next            = 1'b1;
                result_next.rect_sum = signed'(acc_reg + term);
                result_next.bad_query = 1'b0;
                state_next           = S_IDLE;
            end
            S_EMIT:
            begin
                done_next             = 1'b1;
                result_next.rect_sum  = '0;
                result_next.bad_query = 1'b1;
                state_next            = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (pop)
        begin
            addr_next     = head.addr;
            term_en_next  = head.term_en;
            data_next     = head.data;
            acc_next      = '0;
            k_next        = '0;
            prev_use_next = 1'b0;
            prev_neg_next = 1'b0;
            unique case (head.op)
                satq_pkg::OP_LOAD:  state_next = head.term_en[1] ? S_LD_RD : S_LD_WR;
                satq_pkg::OP_QUERY: state_next = S_Q_RUN;
                satq_pkg::OP_BAD:   state_next = S_EMIT;
                default:            state_next = S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            addr_reg     <= '0;
            term_en_reg  <= '0;
            data_reg     <= '0;
            acc_reg      <= '0;
            k_reg        <= '0;
            prev_use_reg <= 1'b0;
            prev_neg_reg <= 1'b0;
            done_reg     <= 1'b0;
            result_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            addr_reg     <= addr_next;
            term_en_reg  <= term_en_next;
            data_reg     <= data_next;
            acc_reg      <= acc_next;
            k_reg        <= k_next;
            prev_use_reg <= prev_use_next;
            prev_neg_reg <= prev_neg_next;
            done_reg     <= done_next;
            result_reg   <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

    `SATQ_ASSERT_NEXT(a_drain_strobes_sum, state_reg == S_Q_DRAIN, done_reg && !result_reg.bad_query, "query drain did not strobe a good result")
    `SATQ_ASSERT_NEXT(a_emit_strobes_bad, state_reg == S_EMIT, done_reg && result_reg.bad_query && result_reg.rect_sum == '0, "bad query did not strobe a flagged zero")

endmodule

// ----- design/summed_area_table_query_core.sv -----
// Top level of the summed-area table query core: front end, transaction queue
// and back end with the prefix table RAM. Depends on satq_pkg and all satq_* modules.
//
//   Channel   Handshake          Payload
//   input     start / busy       item   (satq_pkg::in_item_t)
//   result    done (strobe)      result (satq_pkg::result_t)
//   config    cfg_we             cfg_index, cfg_data
//
// A transaction is taken at each edge where start is high and busy is low; busy
// is high only while the two-entry queue is full. The front end classifies in
// the accept cycle, so the back end sets the rate: all table traffic shares one
// single-port RAM. A load reads the entry above and writes its own (a top-row
// load, with no entry above, only writes); a good query reads four corners and
// then drains, taking the next transaction meanwhile; a bad query is only flagged.
// Each query gives one result on done for exactly one cycle; loads give none.
// The receiver cannot stall. Reset clears the load position, running sum and
// sizes (both 128); the table is not cleared; an entry reads undefined until loaded.
module summed_area_table_query_core #(
    parameter int MAX_ROWS    = 128,
    parameter int MAX_COLS    = 128,
    parameter int VALUE_WIDTH = 16
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    output logic                       busy,
    input  satq_pkg::in_item_t         item,
    output logic                       done,
    output satq_pkg::result_t          result,
    input  logic                       cfg_we,
    input  logic                       cfg_index,
    input  logic [satq_pkg::CFG_W-1:0] cfg_data
);

    logic             accept;
    logic             push;
    logic             pop;
    logic             q_empty;
    logic             q_full;
    satq_pkg::entry_t push_entry;
    satq_pkg::entry_t head_entry;

    // The queue being full is the only reason to hold off a new transaction.
    assign busy   = q_full;
    assign accept = start && !q_full;

    satq_front #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLS    (MAX_COLS),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .item      (item),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .entry     (push_entry)
    );

    satq_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_entry),
        .pop       (pop),
        .pop_data  (head_entry),
        .empty     (q_empty),
        .full      (q_full)
    );

    satq_back #(
        .MAX_ROWS (MAX_ROWS),
        .MAX_COLS (MAX_COLS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .empty  (q_empty),
        .head   (head_entry),
        .pop    (pop),
        .done   (done),
        .result (result)
    );

endmodule

// ----- tb/sv/summed_area_table_query_core_test.sv -----
// Self-checking testbench for the summed-area table query core: matrix loads and
// rectangle queries checked against a predictor of the prefix table kept in a small class.
// Depends on satq_pkg and the summed_area_table_query_core RTL.
module summed_area_table_query_core_test;

    // The block is built with its default sizes, so the predictor mirrors them.
    localparam int ROWS_MAX = 128;
    localparam int COLS_MAX = 128;

    // Transaction kinds carried in item.kind.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic signed [satq_pkg::VAL_W-1:0] VALUE_HI = 16'sh7fff;
    localparam logic signed [satq_pkg::VAL_W-1:0] VALUE_LO = 16'sh8000;

    // Cycles allowed for queued loads to drain once no query result is pending.
    // It covers the two queue slots plus the one in the back end.
    localparam int SETTLE_CYCLES = 32;
    localparam int CYCLE_LIMIT   = 200000;

    // Sender idle percentage per phase, and the size settings used in each phase.
    // Zero and values above 128 check that the sizes saturate to 1..128.
    localparam int PHASE_IDLE [3] = '{17, 85, 0};
    localparam int SET_ROWS   [9] = '{3, 0, 5, 1, 2, 255, 128, 9, 8};
    localparam int SET_COLS   [9] = '{4, 255, 7, 1, 128, 1, 2, 0, 8};

    // The class keeps its own copy of the prefix table, the load position, the
    // row running sum and both size registers. Every accepted transaction is
    // applied to that copy; each query pushes the result it must produce.
    class rect_sum_board;
        logic [satq_pkg::SUM_W-1:0] sums [ROWS_MAX*COLS_MAX];
        bit                         loaded [ROWS_MAX*COLS_MAX];
        int                         at_row;
        int                         at_col;
        logic [satq_pkg::SUM_W-1:0] row_acc;
        logic [satq_pkg::CFG_W-1:0] rows_reg;
        logic [satq_pkg::CFG_W-1:0] cols_reg;
        satq_pkg::result_t          due [$];
        int                         errors;

        function new();
            at_row   = 0;
            at_col   = 0;
            row_acc  = '0;
            rows_reg = satq_pkg::SIZE_RESET;
            cols_reg = satq_pkg::SIZE_RESET;
            errors   = 0;
        endfunction

        function int clamp_size(logic [satq_pkg::CFG_W-1:0] v, int top);
            if (v == 0)
                return 1;
            if (int'(v) > top)
                return top;
            return int'(v);
        endfunction

        function int rows_used();
            return clamp_size(rows_reg, ROWS_MAX);
        endfunction

        function int cols_used();
            return clamp_size(cols_reg, COLS_MAX);
        endfunction

        function int slot(int r, int c);
            return r * COLS_MAX + c;
        endfunction

        // A size write restarts loading at the first entry but keeps the table.
        function void write_size(logic idx, logic [satq_pkg::CFG_W-1:0] d);
            if (idx == satq_pkg::REG_NUM_ROWS)
                rows_reg = d;
            else
                cols_reg = d;
            at_row  = 0;
            at_col  = 0;
            row_acc = '0;
        endfunction

        function bit rect_bad(satq_pkg::in_item_t it);
            return it.top_row > it.bottom_row || it.left_col > it.right_col ||
                   int'(it.bottom_row) >= rows_used() || int'(it.right_col) >= cols_used();
        endfunction

        // True when the query is flagged, or when every corner it reads has been loaded.
        function bit query_safe(satq_pkg::in_item_t it);
            int t;
            int l;
            int b;
            int r;
            bit ok;
            t = int'(it.top_row);
            l = int'(it.left_col);
            b = int'(it.bottom_row);
            r = int'(it.right_col);
            if (rect_bad(it))
                return 1'b1;
            ok = loaded[slot(b, r)];
            if (t > 0)
                ok &= loaded[slot(t - 1, r)];
            if (l > 0)
                ok &= loaded[slot(b, l - 1)];
            if (t > 0 && l > 0)
                ok &= loaded[slot(t - 1, l - 1)];
            return ok;
        endfunction

        function void take_item(satq_pkg::in_item_t it);
            logic [satq_pkg::SUM_W-1:0] above;
            logic [satq_pkg::SUM_W-1:0] s;
            satq_pkg::result_t          want;
            int                         t;
            int                         l;
            int                         b;
            int                         r;
            if (it.kind == KIND_LOAD) begin
                above   = (at_row > 0) ? sums[slot(at_row - 1, at_col)] : '0;
                row_acc = row_acc +
                          {{(satq_pkg::SUM_W-satq_pkg::VAL_W){it.value[satq_pkg::VAL_W-1]}},
                           it.value};
                sums[slot(at_row, at_col)]   = row_acc + above;
                loaded[slot(at_row, at_col)] = 1'b1;
                at_col++;
                if (at_col >= cols_used()) begin
                    at_col  = 0;
                    row_acc = '0;
                    at_row++;
                    if (at_row >= rows_used())
                        at_row = 0;
                end
                return;
            end
            if (rect_bad(it)) begin
                want.rect_sum  = '0;
                want.bad_query = 1'b1;
            end
            else begin
                t = int'(it.top_row);
                l = int'(it.left_col);
                b = int'(it.bottom_row);
                r = int'(it.right_col);
                s = sums[slot(b, r)];
                if (t > 0)
                    s -= sums[slot(t - 1, r)];
                if (l > 0)
                    s -= sums[slot(b, l - 1)];
                if (t > 0 && l > 0)
                    s += sums[slot(t - 1, l - 1)];
                want.rect_sum  = s;
                want.bad_query = 1'b0;
            end
            due.push_back(want);
        endfunction

        function void compare_result(satq_pkg::result_t got);
            satq_pkg::result_t want;
            if (due.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("result with nothing pending: rect_sum %0d bad_query %0b",
                             got.rect_sum, got.bad_query);
                return;
            end
            want = due.pop_front();
            if (got.rect_sum !== want.rect_sum || got.bad_query !== want.bad_query) begin
                errors++;
                if (errors <= 10)
                    $display("result mismatch: expected rect_sum %0d bad_query %0b, got %0d %0b",
                             want.rect_sum, want.bad_query, got.rect_sum, got.bad_query);
            end
        endfunction
    endclass

    logic                       clk       = 1'b0;
    logic                       rst_n     = 1'b0;
    logic                       start     = 1'b0;
    logic                       busy;
    satq_pkg::in_item_t         item      = '0;
    logic                       done;
    satq_pkg::result_t          result;
    logic                       cfg_we    = 1'b0;
    logic                       cfg_index = 1'b0;
    logic [satq_pkg::CFG_W-1:0] cfg_data  = '0;

    rect_sum_board board = new();
    int unsigned   cycles = 0;
    int            sender_idle_pct = 0;

    summed_area_table_query_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .item      (item),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // Monitor. All values are sampled at the rising edge, before the block's own
    // updates for that edge land, so each read sees what the edge acts on. The
    // result is checked before the new transaction is noted, although a query
    // can never produce its result at the edge that accepts it.
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (done)
                board.compare_result(result);
            if (start && !busy)
                board.take_item(item);
            if (cfg_we)
                board.write_size(cfg_index, cfg_data);
        end
    end

    // The timeout ends a run that hangs, for example when a result never comes.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic satq_pkg::in_item_t rand_item(logic kind);
        satq_pkg::in_item_t it;
        it.kind       = kind;
        it.value      = satq_pkg::VAL_W'($urandom);
        it.top_row    = satq_pkg::IDX_W'($urandom);
        it.left_col   = satq_pkg::IDX_W'($urandom);
        it.bottom_row = satq_pkg::IDX_W'($urandom);
        it.right_col  = satq_pkg::IDX_W'($urandom);
        return it;
    endfunction

    function automatic satq_pkg::in_item_t make_load(logic signed [satq_pkg::VAL_W-1:0] v);
        satq_pkg::in_item_t it;
        it       = rand_item(KIND_LOAD);
        it.value = v;
        return it;
    endfunction

    function automatic satq_pkg::in_item_t make_query(int t, int l, int b, int r);
        satq_pkg::in_item_t it;
        it            = rand_item(KIND_QUERY);
        it.top_row    = satq_pkg::IDX_W'(t);
        it.left_col   = satq_pkg::IDX_W'(l);
        it.bottom_row = satq_pkg::IDX_W'(b);
        it.right_col  = satq_pkg::IDX_W'(r);
        return it;
    endfunction

    // Offers one transaction and returns at the edge that accepts it. Start is
    // left high, so a following transaction can go out back to back; any other
    // path must lower start in the same step it takes over.
    task automatic send_item(input satq_pkg::in_item_t it);
        if (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        start <= 1'b1;
        item  <= it;
        do
            @(posedge clk);
        while (busy !== 1'b0);
    endtask

    // Waits until every query has answered and the queued loads have drained.
    task automatic go_quiet();
        start <= 1'b0;
        while (board.due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Writes both size registers while the block is idle. The extra edge at
    // the end makes sure the monitor has applied both writes to the predictor.
    task automatic set_sizes(int rows, int cols);
        go_quiet();
        cfg_we    <= 1'b1;
        cfg_index <= satq_pkg::REG_NUM_ROWS;
        cfg_data  <= satq_pkg::CFG_W'(rows);
        @(posedge clk);
        cfg_index <= satq_pkg::REG_NUM_COLS;
        cfg_data  <= satq_pkg::CFG_W'(cols);
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    // Random mix for one size setting. Queries are mostly well formed rectangles
    // inside the size in use; a rectangle that would touch an entry not yet
    // loaded turns into a load instead, which also keeps filling the table.
    // About one transaction in ten is a query with raw random corners.
    task automatic run_mix(int count);
        satq_pkg::in_item_t it;
        int                 rows;
        int                 cols;
        int                 pick;
        int                 t;
        int                 l;
        rows = board.rows_used();
        cols = board.cols_used();
        repeat (count) begin
            pick = $urandom_range(99);
            it   = rand_item(KIND_LOAD);
            if (pick < 10) begin
                it.kind = KIND_QUERY;
                if (!board.query_safe(it)) begin
                    // Force an inverted rectangle, which reads no entry.
                    it.top_row    = '1;
                    it.bottom_row = '0;
                end
            end
            else if (pick < 55) begin
                if ($urandom_range(7) == 0) begin
                    it = make_query(0, 0, rows - 1, cols - 1);
                end
                else begin
                    t  = $urandom_range(rows - 1);
                    l  = $urandom_range(cols - 1);
                    it = make_query(t, l, $urandom_range(rows - 1, t),
                                    $urandom_range(cols - 1, l));
                end
                if (!board.query_safe(it))
                    it.kind = KIND_LOAD;
            end
            if (it.kind == KIND_LOAD && $urandom_range(7) == 0)
                it.value = ($urandom_range(1) == 1) ? VALUE_HI : VALUE_LO;
            send_item(it);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, first at the reset sizes of 128 by 128: a partly
        // loaded first row holding both value extremes, queried before the
        // matrix is complete, plus inverted rectangles.
        sender_idle_pct = PHASE_IDLE[0];
        send_item(make_load(VALUE_HI));
        send_item(make_load(VALUE_LO));
        send_item(make_load(16'sd1));
        send_item(make_load(-16'sd1));
        send_item(make_query(0, 0, 0, 3));
        send_item(make_query(0, 1, 0, 2));
        send_item(make_query(0, 3, 0, 3));
        send_item(make_query(0, 2, 0, 1));
        send_item(make_query(3, 0, 1, 0));

        // A 2 by 3 matrix: all four corner terms, and corners past the size.
        set_sizes(2, 3);
        send_item(make_load(VALUE_HI));
        send_item(make_load(VALUE_HI));
        send_item(make_load(VALUE_HI));
        send_item(make_load(VALUE_LO));
        send_item(make_load(VALUE_LO));
        send_item(make_load(16'sd5));
        send_item(make_query(0, 0, 1, 2));
        send_item(make_query(1, 1, 1, 2));
        send_item(make_query(1, 0, 1, 0));
        send_item(make_query(0, 2, 0, 2));
        send_item(make_query(0, 0, 2, 0));
        send_item(make_query(0, 0, 0, 3));
        send_item(make_query(1, 0, 0, 0));
        send_item(make_query(0, 2, 0, 1));

        // Random part: three idling phases, three size settings in each.
        for (int p = 0; p < 3; p++) begin
            sender_idle_pct = PHASE_IDLE[p];
            for (int s = 0; s < 3; s++) begin
                set_sizes(SET_ROWS[3*p + s], SET_COLS[3*p + s]);
                run_mix(board.rows_used() * board.cols_used() + 10);
            end
        end

        go_quiet();
        if (board.errors == 0 && board.due.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
